@@ rtl/circle_segment_contact_core_macros.svh @@
// assertion macros for the circle segment contact core checker
// no dependencies; included by the checker file
`ifndef CIRCLE_SEGMENT_CONTACT_CORE_MACROS_SVH
`define CIRCLE_SEGMENT_CONTACT_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define CSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define CSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/csc_pkg.sv @@
// shared types, widths and helpers for the circle segment contact core
// no dependencies
`timescale 1ns / 1ps

package csc_pkg;

  localparam int CW       = 32;           // coordinate width
  localparam int NFB      = 14;           // normal fraction bits
  localparam int NW       = NFB + 2;      // normal width
  localparam int RW       = CW - 1;       // radius width
  localparam int TFB      = CW + 2;       // projection fraction bits
  localparam int TQ_W     = TFB + 1;      // projection fraction incl. exact one
  localparam int TQ_LO    = TQ_W / 2;     // split point of the t multiply
  localparam int DW       = CW + 1;       // coordinate difference width
  localparam int PW       = 2 * DW;       // product width
  localparam int SW       = PW + 1;       // sum of two products
  localparam int RT1_W    = (SW + 1) / 2; // root of a squared length
  localparam int NRM_W    = 31;           // normalized magnitude width
  localparam int NRM_TOP  = 30;           // target leading one position
  localparam int L2_W     = 2 * NRM_W + 1;
  localparam int N2_EXT   = 32;
  localparam int N2_W     = L2_W + N2_EXT;
  localparam int RT2_W    = (N2_W + 1) / 2;
  localparam int NSH      = NFB + 16;
  localparam int NDV_W    = NRM_W + NSH + 1;
  localparam int LP_W     = $clog2(DW);
  localparam logic [NW-1:0] NORM_ONE = NW'(1) << NFB;

  typedef struct packed {
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic        [RW-1:0] circle_radius;
    logic signed [CW-1:0] seg_p_x;
    logic signed [CW-1:0] seg_p_y;
    logic signed [CW-1:0] seg_q_x;
    logic signed [CW-1:0] seg_q_y;
  } csc_req_t;

  typedef struct packed {
    logic                 hit;
    logic signed [NW-1:0] normal_x;
    logic signed [NW-1:0] normal_y;
    logic        [RW-1:0] penetration;
  } csc_res_t;

  function automatic logic signed [DW-1:0] sext_coord(input logic signed [CW-1:0] a);
    return {a[CW-1], a};
  endfunction

  function automatic logic [DW-1:0] mag_diff(input logic signed [DW-1:0] a);
    logic signed [DW-1:0] n;
    n = -a;
    return a[DW-1] ? n : a;
  endfunction

endpackage

@@ rtl/csc_sqrt_pipe.sv @@
// pipelined integer square root, one root bit per stage, with remainder
// standalone; sideband rides along with each request
`timescale 1ns / 1ps

module csc_sqrt_pipe #(
  parameter int IN_W   = 67,
  parameter int RT_W   = 34,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   radicand,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [RT_W-1:0]   root,
  output logic [RT_W:0]     rem,
  output logic [SIDE_W-1:0] out_side
);

  localparam int AW = 2 * RT_W + 1;

  logic              vld   [1:RT_W];
  logic [AW-1:0]     rem_q [1:RT_W];
  logic [RT_W-1:0]   root_q[1:RT_W];
  logic [SIDE_W-1:0] side_q[1:RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_stage
    localparam int B = RT_W - 1 - k;
    logic              cur_v;
    logic [AW-1:0]     cur_rem;
    logic [RT_W-1:0]   cur_root;
    logic [SIDE_W-1:0] cur_side;
    logic [AW-1:0]     trial;

    if (k == 0) begin : g_first
      assign cur_v    = in_valid;
      assign cur_rem  = AW'(radicand);
      assign cur_root = '0;
      assign cur_side = in_side;
    end else begin : g_rest
      assign cur_v    = vld[k];
      assign cur_rem  = rem_q[k];
      assign cur_root = root_q[k];
      assign cur_side = side_q[k];
    end

    // (2*root + 2^b) * 2^b, root holds only bits above b
    assign trial = ((AW'(cur_root) << 1) | (AW'(1) << B)) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[k+1] <= cur_side;
        if (cur_rem >= trial) begin
          rem_q[k+1]  <= cur_rem - trial;
          root_q[k+1] <= cur_root | (RT_W'(1) << B);
        end else begin
          rem_q[k+1]  <= cur_rem;
          root_q[k+1] <= cur_root;
        end
      end
    end
  end

  assign out_valid = vld[RT_W];
  assign root      = root_q[RT_W];
  assign rem       = rem_q[RT_W][RT_W:0];
  assign out_side  = side_q[RT_W];

endmodule

@@ rtl/csc_div_pipe.sv @@
// pipelined restoring divider, one quotient bit per stage
// needs dividend < divisor * 2^Q_W; standalone
`timescale 1ns / 1ps

module csc_div_pipe #(
  parameter int DVD_W  = 101,
  parameter int DVS_W  = 67,
  parameter int Q_W    = 34,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [DVS_W-1:0]  divisor,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q_W-1:0]    quotient,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld   [1:Q_W];
  logic [DVS_W-1:0]  rem_q [1:Q_W];
  logic [Q_W-1:0]    dq_q  [1:Q_W];
  logic [DVS_W-1:0]  dvs_q [1:Q_W];
  logic [SIDE_W-1:0] side_q[1:Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic              cur_v;
    logic [DVS_W-1:0]  cur_rem;
    logic [Q_W-1:0]    cur_dq;
    logic [DVS_W-1:0]  cur_dvs;
    logic [SIDE_W-1:0] cur_side;
    logic [DVS_W:0]    sh;
    logic [DVS_W:0]    dif;
    logic              ge;

    if (k == 0) begin : g_first
      assign cur_v    = in_valid;
      assign cur_rem  = DVS_W'(dividend >> Q_W);
      assign cur_dq   = dividend[Q_W-1:0];
      assign cur_dvs  = divisor;
      assign cur_side = in_side;
    end else begin : g_rest
      assign cur_v    = vld[k];
      assign cur_rem  = rem_q[k];
      assign cur_dq   = dq_q[k];
      assign cur_dvs  = dvs_q[k];
      assign cur_side = side_q[k];
    end

    assign sh  = {cur_rem, cur_dq[Q_W-1]};
    assign ge  = sh >= {1'b0, cur_dvs};
    assign dif = sh - {1'b0, cur_dvs};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1]  <= ge ? dif[DVS_W-1:0] : sh[DVS_W-1:0];
        dq_q[k+1]   <= {cur_dq[Q_W-2:0], ge};
        dvs_q[k+1]  <= cur_dvs;
        side_q[k+1] <= cur_side;
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign quotient  = dq_q[Q_W];
  assign out_side  = side_q[Q_W];

endmodule

@@ rtl/circle_segment_contact_core.sv @@
// circle versus segment contact: hit flag, unit normal and penetration depth
// the pipe holds 4 setup stages, a 34-stage projection divider, 6 stages,
// a 34-stage distance root, 5 stages, a 48-stage normal root, 1 stage,
// a 16-stage normal divider and the output register; throughput one request per cycle,
// as every stage moves together, halted only while a result waits on res_stall
// synchronous reset clears the valid bits; no clearing pass
`timescale 1ns / 1ps

module circle_segment_contact_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  csc_pkg::csc_req_t req_data,
  output logic              res_valid,
  input  logic              res_stall,
  output csc_pkg::csc_res_t res_data
);

  localparam int DW    = csc_pkg::DW;
  localparam int PW    = csc_pkg::PW;
  localparam int SW    = csc_pkg::SW;
  localparam int RW    = csc_pkg::RW;
  localparam int TFB   = csc_pkg::TFB;
  localparam int TQ_W  = csc_pkg::TQ_W;
  localparam int TQ_LO = csc_pkg::TQ_LO;
  localparam int RT1_W = csc_pkg::RT1_W;
  localparam int RT2_W = csc_pkg::RT2_W;
  localparam int NRM_W = csc_pkg::NRM_W;
  localparam int NDV_W = csc_pkg::NDV_W;
  localparam int LP_W  = csc_pkg::LP_W;
  localparam int NW    = csc_pkg::NW;

  typedef struct packed {
    logic                 proj;
    logic                 eq;
    logic                 hitb;
    logic signed [DW-1:0] vbx;
    logic signed [DW-1:0] vby;
    logic [SW-1:0]        lenb;
    logic [2*RW-1:0]      r2;
    logic signed [DW-1:0] ax;
    logic signed [DW-1:0] ay;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [RW-1:0]        r;
  } side4_t;

  typedef struct packed {
    logic                 hit;
    logic [RW-1:0]        r;
    logic signed [DW-1:0] vx;
    logic signed [DW-1:0] vy;
  } sidel_t;

  typedef struct packed {
    logic              hit;
    logic [RW-1:0]     pen;
    logic [NRM_W-1:0]  nx;
    logic [NRM_W-1:0]  ny;
    logic              sgx;
    logic              sgy;
    logic              mzero;
  } siden_t;

  typedef struct packed {
    logic          hit;
    logic [RW-1:0] pen;
    logic          mzero;
    logic          sgx;
  } sidex_t;

  logic en;
  assign en        = !(res_valid && res_stall);
  assign req_stall = !en;

  // stage 1: differences
  logic v1;
  logic signed [DW-1:0] s1_ax, s1_ay, s1_dx, s1_dy, s1_wx, s1_wy, s1_zx, s1_zy;
  logic [RW-1:0] s1_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ax <= csc_pkg::sext_coord(req_data.center_x) - csc_pkg::sext_coord(req_data.seg_p_x);
      s1_ay <= csc_pkg::sext_coord(req_data.center_y) - csc_pkg::sext_coord(req_data.seg_p_y);
      s1_dx <= csc_pkg::sext_coord(req_data.seg_q_x) - csc_pkg::sext_coord(req_data.seg_p_x);
      s1_dy <= csc_pkg::sext_coord(req_data.seg_q_y) - csc_pkg::sext_coord(req_data.seg_p_y);
      s1_wx <= csc_pkg::sext_coord(req_data.seg_p_x) - csc_pkg::sext_coord(req_data.center_x);
      s1_wy <= csc_pkg::sext_coord(req_data.seg_p_y) - csc_pkg::sext_coord(req_data.center_y);
      s1_zx <= csc_pkg::sext_coord(req_data.seg_q_x) - csc_pkg::sext_coord(req_data.center_x);
      s1_zy <= csc_pkg::sext_coord(req_data.seg_q_y) - csc_pkg::sext_coord(req_data.center_y);
      s1_r  <= req_data.circle_radius;
    end
  end

  // stage 2: products
  logic v2;
  logic signed [PW-1:0] s2_na, s2_nb, s2_dxx, s2_dyy, s2_wxx, s2_wyy, s2_zxx, s2_zyy;
  logic [2*RW-1:0] s2_r2;
  logic signed [DW-1:0] s2_ax, s2_ay, s2_dx, s2_dy, s2_wx, s2_wy, s2_zx, s2_zy;
  logic [RW-1:0] s2_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_na  <= s1_ax * s1_dx;
      s2_nb  <= s1_ay * s1_dy;
      s2_dxx <= s1_dx * s1_dx;
      s2_dyy <= s1_dy * s1_dy;
      s2_wxx <= s1_wx * s1_wx;
      s2_wyy <= s1_wy * s1_wy;
      s2_zxx <= s1_zx * s1_zx;
      s2_zyy <= s1_zy * s1_zy;
      s2_r2  <= (2*RW)'(s1_r) * (2*RW)'(s1_r);
      s2_ax  <= s1_ax;
      s2_ay  <= s1_ay;
      s2_dx  <= s1_dx;
      s2_dy  <= s1_dy;
      s2_wx  <= s1_wx;
      s2_wy  <= s1_wy;
      s2_zx  <= s1_zx;
      s2_zy  <= s1_zy;
      s2_r   <= s1_r;
    end
  end

  // stage 3: sums
  logic v3;
  logic signed [SW-1:0] s3_num;
  logic [SW-1:0] s3_den, s3_l1, s3_l2;
  logic [2*RW-1:0] s3_r2;
  logic signed [DW-1:0] s3_ax, s3_ay, s3_dx, s3_dy, s3_wx, s3_wy, s3_zx, s3_zy;
  logic [RW-1:0] s3_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_num <= {s2_na[PW-1], s2_na} + {s2_nb[PW-1], s2_nb};
      s3_den <= {1'b0, s2_dxx} + {1'b0, s2_dyy};
      s3_l1  <= {1'b0, s2_wxx} + {1'b0, s2_wyy};
      s3_l2  <= {1'b0, s2_zxx} + {1'b0, s2_zyy};
      s3_r2  <= s2_r2;
      s3_ax  <= s2_ax;
      s3_ay  <= s2_ay;
      s3_dx  <= s2_dx;
      s3_dy  <= s2_dy;
      s3_wx  <= s2_wx;
      s3_wy  <= s2_wy;
      s3_zx  <= s2_zx;
      s3_zy  <= s2_zy;
      s3_r   <= s2_r;
    end
  end

  // stage 4: choose projection or nearer endpoint
  logic v4;
  side4_t s4;
  logic [SW-1:0] s4_num, s4_den;
  logic [SW-1:0] r2_ext;
  logic pick_p;

  assign r2_ext = SW'(s3_r2);
  assign pick_p = s3_l1 < s3_l2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4.proj <= (s3_den != '0) && !s3_num[SW-1] && ($unsigned(s3_num) <= s3_den);
      s4.eq   <= $unsigned(s3_num) == s3_den;
      s4.hitb <= (s3_l1 < r2_ext) || (s3_l2 < r2_ext);
      s4.vbx  <= pick_p ? s3_wx : s3_zx;
      s4.vby  <= pick_p ? s3_wy : s3_zy;
      s4.lenb <= pick_p ? s3_l1 : s3_l2;
      s4.r2   <= s3_r2;
      s4.ax   <= s3_ax;
      s4.ay   <= s3_ay;
      s4.dx   <= s3_dx;
      s4.dy   <= s3_dy;
      s4.r    <= s3_r;
      s4_num  <= $unsigned(s3_num);
      s4_den  <= s3_den;
    end
  end

  // projection fraction t
  logic              d1_valid;
  logic [TFB-1:0]    d1_q;
  side4_t            d1_side;
  logic [SW+TFB-1:0] d1_dvd;

  assign d1_dvd = (s4.proj && !s4.eq) ? {s4_num, TFB'(0)} : '0;

  csc_div_pipe #(
    .DVD_W (SW + TFB),
    .DVS_W (SW),
    .Q_W   (TFB),
    .SIDE_W($bits(side4_t))
  ) u_frac_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v4),
    .dividend (d1_dvd),
    .divisor  (s4_den),
    .in_side  (s4),
    .out_valid(d1_valid),
    .quotient (d1_q),
    .out_side (d1_side)
  );

  // p1: partial products of |d| * t
  logic [TQ_W-1:0] tq;
  logic [DW-1:0]   mdx, mdy;
  assign tq  = d1_side.eq ? (TQ_W'(1) << TFB) : {1'b0, d1_q};
  assign mdx = csc_pkg::mag_diff(d1_side.dx);
  assign mdy = csc_pkg::mag_diff(d1_side.dy);

  logic vp1;
  logic [DW+TQ_LO-1:0]      p1_xl, p1_yl;
  logic [DW+TQ_W-TQ_LO-1:0] p1_xh, p1_yh;
  logic p1_negx, p1_negy;
  side4_t p1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp1 <= 1'b0;
    end else if (en) begin
      vp1 <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_xl   <= (DW+TQ_LO)'(mdx) * (DW+TQ_LO)'(tq[TQ_LO-1:0]);
      p1_yl   <= (DW+TQ_LO)'(mdy) * (DW+TQ_LO)'(tq[TQ_LO-1:0]);
      p1_xh   <= (DW+TQ_W-TQ_LO)'(mdx) * (DW+TQ_W-TQ_LO)'(tq[TQ_W-1:TQ_LO]);
      p1_yh   <= (DW+TQ_W-TQ_LO)'(mdy) * (DW+TQ_W-TQ_LO)'(tq[TQ_W-1:TQ_LO]);
      p1_negx <= d1_side.dx[DW-1];
      p1_negy <= d1_side.dy[DW-1];
      p1      <= d1_side;
    end
  end

  // p2: round half away from zero and drop the fraction
  localparam int PS_W = DW + TQ_W + 1;
  logic [PS_W-1:0] sum_x, sum_y;
  assign sum_x = (PS_W'(p1_xh) << TQ_LO) + PS_W'(p1_xl) + (PS_W'(1) << (TFB - 1));
  assign sum_y = (PS_W'(p1_yh) << TQ_LO) + PS_W'(p1_yl) + (PS_W'(1) << (TFB - 1));

  logic vp2;
  logic [DW-1:0] p2_qx, p2_qy;
  logic p2_negx, p2_negy;
  side4_t p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp2 <= 1'b0;
    end else if (en) begin
      vp2 <= vp1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_qx   <= DW'(sum_x >> TFB);
      p2_qy   <= DW'(sum_y >> TFB);
      p2_negx <= p1_negx;
      p2_negy <= p1_negy;
      p2      <= p1;
    end
  end

  // p3: contact vector on the segment
  logic signed [DW:0] sq_x, sq_y, va_x, va_y;
  assign sq_x = p2_negx ? -$signed({1'b0, p2_qx}) : $signed({1'b0, p2_qx});
  assign sq_y = p2_negy ? -$signed({1'b0, p2_qy}) : $signed({1'b0, p2_qy});
  assign va_x = sq_x - {p2.ax[DW-1], p2.ax};
  assign va_y = sq_y - {p2.ay[DW-1], p2.ay};

  logic vp3;
  logic signed [DW-1:0] p3_vx, p3_vy;
  side4_t p3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp3 <= 1'b0;
    end else if (en) begin
      vp3 <= vp2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_vx <= va_x[DW-1:0];
      p3_vy <= va_y[DW-1:0];
      p3    <= p2;
    end
  end

  // p4: squares
  logic vp4;
  logic signed [PW-1:0] p4_xx, p4_yy;
  logic signed [DW-1:0] p4_vx, p4_vy;
  side4_t p4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp4 <= 1'b0;
    end else if (en) begin
      vp4 <= vp3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_xx <= p3_vx * p3_vx;
      p4_yy <= p3_vy * p3_vy;
      p4_vx <= p3_vx;
      p4_vy <= p3_vy;
      p4    <= p3;
    end
  end

  // p5: squared length
  logic vp5;
  logic [SW-1:0] p5_len;
  logic signed [DW-1:0] p5_vx, p5_vy;
  side4_t p5;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp5 <= 1'b0;
    end else if (en) begin
      vp5 <= vp4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p5_len <= {1'b0, p4_xx} + {1'b0, p4_yy};
      p5_vx  <= p4_vx;
      p5_vy  <= p4_vy;
      p5     <= p4;
    end
  end

  // p6: hit test and path merge
  logic vp6;
  sidel_t p6;
  logic [SW-1:0] p6_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp6 <= 1'b0;
    end else if (en) begin
      vp6 <= vp5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p6.hit <= p5.proj ? (p5_len < SW'(p5.r2)) : p5.hitb;
      p6.r   <= p5.r;
      p6.vx  <= p5.proj ? p5_vx : p5.vbx;
      p6.vy  <= p5.proj ? p5_vy : p5.vby;
      p6_len <= p5.proj ? p5_len : p5.lenb;
    end
  end

  // distance root
  logic            l_valid;
  logic [RT1_W-1:0] l_root;
  logic [RT1_W:0]   l_rem;
  sidel_t          l_side;

  csc_sqrt_pipe #(
    .IN_W  (SW),
    .RT_W  (RT1_W),
    .SIDE_W($bits(sidel_t))
  ) u_len_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vp6),
    .radicand (p6_len),
    .in_side  (p6),
    .out_valid(l_valid),
    .root     (l_root),
    .rem      (l_rem),
    .out_side (l_side)
  );

  // q1: round the distance, magnitudes of the contact vector
  logic [DW-1:0] amx, amy;
  assign amx = csc_pkg::mag_diff(l_side.vx);
  assign amy = csc_pkg::mag_diff(l_side.vy);

  logic vq1;
  logic [RT1_W:0] q1_dist;
  logic [DW-1:0] q1_ax, q1_ay, q1_m;
  logic q1_hit, q1_sgx, q1_sgy;
  logic [RW-1:0] q1_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      vq1 <= 1'b0;
    end else if (en) begin
      vq1 <= l_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_dist <= {1'b0, l_root} + (RT1_W+1)'(l_rem > {1'b0, l_root});
      q1_ax   <= amx;
      q1_ay   <= amy;
      q1_m    <= (amx > amy) ? amx : amy;
      q1_hit  <= l_side.hit;
      q1_sgx  <= l_side.vx[DW-1];
      q1_sgy  <= l_side.vy[DW-1];
      q1_r    <= l_side.r;
    end
  end

  // q2: penetration and leading one of the larger magnitude
  logic [LP_W-1:0] lead;
  always_comb begin
    lead = '0;
    for (int i = 0; i < DW; i++) begin
      if (q1_m[i]) begin
        lead = LP_W'(i);
      end
    end
  end

  logic vq2;
  logic [RW-1:0] q2_pen;
  logic [LP_W-1:0] q2_lead;
  logic [DW-1:0] q2_ax, q2_ay;
  logic q2_hit, q2_sgx, q2_sgy, q2_mzero;

  always_ff @(posedge clk) begin
    if (rst) begin
      vq2 <= 1'b0;
    end else if (en) begin
      vq2 <= vq1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q2_pen   <= ((RT1_W+1)'(q1_r) > q1_dist) ? RW'((RT1_W+1)'(q1_r) - q1_dist) : '0;
      q2_lead  <= lead;
      q2_ax    <= q1_ax;
      q2_ay    <= q1_ay;
      q2_hit   <= q1_hit;
      q2_sgx   <= q1_sgx;
      q2_sgy   <= q1_sgy;
      q2_mzero <= q1_m == '0;
    end
  end

  // q3: normalize so the larger magnitude has its top bit at NRM_TOP
  localparam int SH_W = NRM_W + DW;
  logic [NRM_W-1:0] nrm_x, nrm_y;
  always_comb begin
    if (q2_lead >= LP_W'(csc_pkg::NRM_TOP)) begin
      nrm_x = NRM_W'(q2_ax >> (q2_lead - LP_W'(csc_pkg::NRM_TOP)));
      nrm_y = NRM_W'(q2_ay >> (q2_lead - LP_W'(csc_pkg::NRM_TOP)));
    end else begin
      nrm_x = NRM_W'(SH_W'(q2_ax) << (LP_W'(csc_pkg::NRM_TOP) - q2_lead));
      nrm_y = NRM_W'(SH_W'(q2_ay) << (LP_W'(csc_pkg::NRM_TOP) - q2_lead));
    end
  end

  logic vq3;
  siden_t q3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vq3 <= 1'b0;
    end else if (en) begin
      vq3 <= vq2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q3.hit   <= q2_hit;
      q3.pen   <= q2_pen;
      q3.nx    <= nrm_x;
      q3.ny    <= nrm_y;
      q3.sgx   <= q2_sgx;
      q3.sgy   <= q2_sgy;
      q3.mzero <= q2_mzero;
    end
  end

  // q4: squares of the normalized vector
  logic vq4;
  logic [2*NRM_W-1:0] q4_xx, q4_yy;
  siden_t q4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vq4 <= 1'b0;
    end else if (en) begin
      vq4 <= vq3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q4_xx <= (2*NRM_W)'(q3.nx) * (2*NRM_W)'(q3.nx);
      q4_yy <= (2*NRM_W)'(q3.ny) * (2*NRM_W)'(q3.ny);
      q4    <= q3;
    end
  end

  // q5: squared length of the normalized vector
  logic vq5;
  logic [csc_pkg::L2_W-1:0] q5_l2;
  siden_t q5;

  always_ff @(posedge clk) begin
    if (rst) begin
      vq5 <= 1'b0;
    end else if (en) begin
      vq5 <= vq4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q5_l2 <= {1'b0, q4_xx} + {1'b0, q4_yy};
      q5    <= q4;
    end
  end

  // normal length root
  logic              n_valid;
  logic [RT2_W-1:0]  n_root;
  logic [RT2_W:0]    n_rem;
  siden_t            n_side;

  csc_sqrt_pipe #(
    .IN_W  (csc_pkg::N2_W),
    .RT_W  (RT2_W),
    .SIDE_W($bits(siden_t))
  ) u_nrm_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vq5),
    .radicand ({q5_l2, csc_pkg::N2_EXT'(0)}),
    .in_side  (q5),
    .out_valid(n_valid),
    .root     (n_root),
    .rem      (n_rem),
    .out_side (n_side)
  );

  // r1: rounded-division numerators
  logic vr1;
  logic [NDV_W-1:0] r1_dvx, r1_dvy;
  logic [RT2_W-1:0] r1_s;
  sidex_t r1_sx;
  logic r1_sgy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vr1 <= 1'b0;
    end else if (en) begin
      vr1 <= n_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_dvx      <= (NDV_W'(n_side.nx) << csc_pkg::NSH) + NDV_W'(n_root >> 1);
      r1_dvy      <= (NDV_W'(n_side.ny) << csc_pkg::NSH) + NDV_W'(n_root >> 1);
      r1_s        <= n_root;
      r1_sx.hit   <= n_side.hit;
      r1_sx.pen   <= n_side.pen;
      r1_sx.mzero <= n_side.mzero;
      r1_sx.sgx   <= n_side.sgx;
      r1_sgy      <= n_side.sgy;
    end
  end

  // normal components, one divider lane each
  logic          dx_valid, dy_valid;
  logic [NW-1:0] cx_q, cy_q;
  sidex_t        dx_side;
  logic          dy_sg;

  csc_div_pipe #(
    .DVD_W (NDV_W),
    .DVS_W (RT2_W),
    .Q_W   (NW),
    .SIDE_W($bits(sidex_t))
  ) u_nx_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vr1),
    .dividend (r1_dvx),
    .divisor  (r1_s),
    .in_side  (r1_sx),
    .out_valid(dx_valid),
    .quotient (cx_q),
    .out_side (dx_side)
  );

  csc_div_pipe #(
    .DVD_W (NDV_W),
    .DVS_W (RT2_W),
    .Q_W   (NW),
    .SIDE_W(1)
  ) u_ny_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vr1),
    .dividend (r1_dvy),
    .divisor  (r1_s),
    .in_side  (r1_sgy),
    .out_valid(dy_valid),
    .quotient (cy_q),
    .out_side (dy_sg)
  );

  // output register: clamp, sign, zero on miss; zero normal for a zero contact vector
  logic [NW-1:0] cx_c, cy_c;
  logic          keep_n;
  assign cx_c   = (cx_q > csc_pkg::NORM_ONE) ? csc_pkg::NORM_ONE : cx_q;
  assign cy_c   = (cy_q > csc_pkg::NORM_ONE) ? csc_pkg::NORM_ONE : cy_q;
  assign keep_n = dx_side.hit && !dx_side.mzero;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= dx_valid && dy_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_data.hit         <= dx_side.hit;
      res_data.normal_x    <= !keep_n ? '0 : (dx_side.sgx ? -cx_c : cx_c);
      res_data.normal_y    <= !keep_n ? '0 : (dy_sg ? -cy_c : cy_c);
      res_data.penetration <= dx_side.hit ? dx_side.pen : '0;
    end
  end

endmodule

@@ rtl/csc_checker.sv @@
// port-level checker for the circle segment contact core, bound to the top level
// depends on csc_pkg and circle_segment_contact_core_macros.svh
`timescale 1ns / 1ps
`include "circle_segment_contact_core_macros.svh"

module csc_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_stall,
  input logic              res_valid,
  input logic              res_stall,
  input csc_pkg::csc_res_t res_data
);

  logic signed [csc_pkg::NW-1:0] one_s;
  logic signed [csc_pkg::NW-1:0] mone_s;
  assign one_s  = csc_pkg::NORM_ONE;
  assign mone_s = -csc_pkg::NORM_ONE;

  // the whole pipe halts only while a result is held
  `CSC_ASSERT_NOW(a_stall_link, clk, rst, 1'b1,
    req_stall == (res_valid && res_stall),
    "input stall does not follow a held result")

  `CSC_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall,
    res_valid && $stable(res_data), "held result changed")

  // a miss carries no normal and no depth
  `CSC_ASSERT_NOW(a_miss_zero, clk, rst, res_valid && !res_data.hit,
    res_data.normal_x == 0 && res_data.normal_y == 0 && res_data.penetration == 0,
    "miss with nonzero fields")

  `CSC_ASSERT_NOW(a_normal_range, clk, rst, res_valid && res_data.hit,
    res_data.normal_x <= one_s && res_data.normal_x >= mone_s &&
    res_data.normal_y <= one_s && res_data.normal_y >= mone_s,
    "normal outside unit range")

endmodule

bind circle_segment_contact_core csc_checker u_csc_checker (.*);

@@ verif/tb_circle_segment_contact_core.sv @@
// self-checking testbench for circle_segment_contact_core: directed and random contacts
// checked against a built-in contact predictor; depends on csc_pkg and the core rtl
`timescale 1ns / 1ps

module tb_circle_segment_contact_core;

  localparam int MAX_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  csc_pkg::csc_req_t req_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  csc_pkg::csc_res_t res_data;

  csc_pkg::csc_res_t expected_contacts[$];
  int errors = 0;
  int cycle_count = 0;
  int hold_cycles = 0;
  bit quiet = 1'b0;

  circle_segment_contact_core uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("circle_segment_contact_core test failed");
      $finish;
    end
  end

  // receiver side: random stall, no stall while quiet, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      res_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (quiet) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(99) < 8);
    end
  end

  function automatic longint unsigned abs_val(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned isqrt128(logic [127:0] n);
    longint unsigned res, c;
    res = 0;
    for (int b = 62; b >= 0; b--) begin
      c = res | (64'd1 << b);
      if (128'(c) * 128'(c) <= n) res = c;
    end
    return res;
  endfunction

  function automatic longint scale_by_t(longint d, longint unsigned tq);
    logic [127:0] p;
    longint q;
    p = 128'(abs_val(d)) * 128'(tq) + (128'd1 << (csc_pkg::TFB - 1));
    q = longint'(p >> csc_pkg::TFB);
    return d < 0 ? -q : q;
  endfunction

  function automatic logic [127:0] sq_len(longint x, longint y);
    return 128'(abs_val(x)) * 128'(abs_val(x)) + 128'(abs_val(y)) * 128'(abs_val(y));
  endfunction

  function automatic void unit_dir(input longint vx, input longint vy,
                                   output longint nx, output longint ny);
    longint unsigned ax, ay, m, l2, s, ux, uy, lim;
    lim = 64'd1 << csc_pkg::NFB;
    ax = abs_val(vx);
    ay = abs_val(vy);
    m = ax > ay ? ax : ay;
    nx = 0;
    ny = 0;
    if (m == 0) return;
    while (m < (64'd1 << 30)) begin
      ax <<= 1; ay <<= 1; m <<= 1;
    end
    while (m >= (64'd1 << 31)) begin
      ax >>= 1; ay >>= 1; m >>= 1;
    end
    l2 = ax * ax + ay * ay;
    s = isqrt128(128'(l2) << 32);
    ux = longint'(((128'(ax) << csc_pkg::NSH) + 128'(s >> 1)) / 128'(s));
    uy = longint'(((128'(ay) << csc_pkg::NSH) + 128'(s >> 1)) / 128'(s));
    if (ux > lim) ux = lim;
    if (uy > lim) uy = lim;
    nx = vx < 0 ? -longint'(ux) : longint'(ux);
    ny = vy < 0 ? -longint'(uy) : longint'(uy);
  endfunction

  function automatic csc_pkg::csc_res_t predict_contact(csc_pkg::csc_req_t r);
    longint cx, cy, px, py, qx, qy, ax, ay, dx, dy, vx, vy, wx, wy, zx, zy, nx, ny;
    logic signed [127:0] sax, say, sdx, sdy, num, den;
    logic [127:0] r2, len, l1, l2;
    longint unsigned tq, rad, s, pen;
    bit hit;
    csc_pkg::csc_res_t res;
    cx = r.center_x; cy = r.center_y;
    px = r.seg_p_x; py = r.seg_p_y;
    qx = r.seg_q_x; qy = r.seg_q_y;
    rad = r.circle_radius;
    ax = cx - px; ay = cy - py; dx = qx - px; dy = qy - py;
    sax = ax; say = ay; sdx = dx; sdy = dy;
    num = sax * sdx + say * sdy;
    den = sdx * sdx + sdy * sdy;
    r2 = 128'(rad) * 128'(rad);
    hit = 0; vx = 0; vy = 0; len = 0; pen = 0; nx = 0; ny = 0;
    if (den != 0 && num >= 0 && num <= den) begin
      tq = (num == den) ? (64'd1 << csc_pkg::TFB)
                        : longint'((num <<< csc_pkg::TFB) / den);
      vx = scale_by_t(dx, tq) - ax;
      vy = scale_by_t(dy, tq) - ay;
      len = sq_len(vx, vy);
      hit = len < r2;
    end else begin
      wx = px - cx; wy = py - cy; zx = qx - cx; zy = qy - cy;
      l1 = sq_len(wx, wy);
      l2 = sq_len(zx, zy);
      if (l1 < r2 || l2 < r2) begin
        hit = 1;
        // ties go to the second endpoint
        if (l1 < l2) begin
          vx = wx; vy = wy; len = l1;
        end else begin
          vx = zx; vy = zy; len = l2;
        end
      end
    end
    if (hit) begin
      s = isqrt128(len);
      if (len - 128'(s) * 128'(s) > 128'(s)) s++;
      pen = rad > s ? rad - s : 0;
      unit_dir(vx, vy, nx, ny);
    end
    res.hit = hit;
    res.normal_x = nx[csc_pkg::NW-1:0];
    res.normal_y = ny[csc_pkg::NW-1:0];
    res.penetration = pen[csc_pkg::RW-1:0];
    return res;
  endfunction

  // compare each accepted result with the oldest expectation
  always @(negedge clk) begin
    csc_pkg::csc_res_t exp_res;
    if (!rst && res_valid && !res_stall) begin
      if (expected_contacts.size() == 0) begin
        $error("unexpected result: hit=%0d", res_data.hit);
        errors++;
      end else begin
        exp_res = expected_contacts.pop_front();
        if (res_data.hit !== exp_res.hit) begin
          $error("hit expected %0d actual %0d", exp_res.hit, res_data.hit);
          errors++;
        end
        if (res_data.normal_x !== exp_res.normal_x) begin
          $error("normal_x expected %0d actual %0d", exp_res.normal_x, res_data.normal_x);
          errors++;
        end
        if (res_data.normal_y !== exp_res.normal_y) begin
          $error("normal_y expected %0d actual %0d", exp_res.normal_y, res_data.normal_y);
          errors++;
        end
        if (res_data.penetration !== exp_res.penetration) begin
          $error("penetration expected %0d actual %0d",
                 exp_res.penetration, res_data.penetration);
          errors++;
        end
      end
    end
  end

  task automatic send_request(csc_pkg::csc_req_t r);
    bit taken;
    while (!quiet && $urandom_range(99) < 8) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= r;
    expected_contacts.push_back(predict_contact(r));
    // stall is stable between edges, so sample it at the falling edge
    do begin
      @(negedge clk);
      taken = !req_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  function automatic csc_pkg::csc_req_t make_req(int cx, int cy, int rad, int px, int py,
                                                 int qx, int qy);
    csc_pkg::csc_req_t r;
    r.center_x = cx; r.center_y = cy; r.circle_radius = rad[csc_pkg::RW-1:0];
    r.seg_p_x = px; r.seg_p_y = py; r.seg_q_x = qx; r.seg_q_y = qy;
    return r;
  endfunction

  // well-formed contact at a random scale around a random center
  function automatic csc_pkg::csc_req_t random_contact();
    int sc, cx, cy;
    sc = $urandom_range(26, 2);
    cx = $urandom;
    cy = $urandom;
    if ($urandom_range(3) == 0) begin
      cx = cx >>> 4;
      cy = cy >>> 4;
    end
    return make_req(cx, cy, $urandom_range(2 ** sc, 0),
                    cx + $signed($urandom_range(2 ** (sc + 1))) - 2 ** sc,
                    cy + $signed($urandom_range(2 ** (sc + 1))) - 2 ** sc,
                    cx + $signed($urandom_range(2 ** (sc + 1))) - 2 ** sc,
                    cy + $signed($urandom_range(2 ** (sc + 1))) - 2 ** sc);
  endfunction

  task automatic test_directed();
    int one, mx, mn;
    one = 1 << 16;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    send_request(make_req(0, 0, one, -10 * one, 0, 10 * one, 0));       // center on segment
    send_request(make_req(0, one / 2, one, -one, 0, one, 0));          // interior projection
    send_request(make_req(0, one, one, -one, 0, one, 0));              // tangent, no hit
    send_request(make_req(0, 0, one, 0, one / 2, 0, one / 2));         // degenerate segment
    send_request(make_req(5, 7, one, 5, 7, 5, 7));                     // degenerate at center
    send_request(make_req(0, 0, one, one / 4, 0, 3 * one, 0));         // before first endpoint
    send_request(make_req(0, 0, one, 3 * one, 0, one / 4, 0));         // beyond second endpoint
    send_request(make_req(0, 0, one, 0, 3 * one, one / 2, 0));         // projection at t = 36/37, near q
    send_request(make_req(0, 0, 2 * one, one, 0, one, 3 * one));       // projection at t = 0
    send_request(make_req(0, 0, one, -one / 2, one, one / 2, one));    // endpoints tie
    send_request(make_req(0, 0, one, one / 2, one / 2, -one / 2, one / 2));
    send_request(make_req(0, 0, 0, 0, 0, one, 0));                     // zero radius
    send_request(make_req(mx, mx, mx, mn, mn, mx, mx));
    send_request(make_req(mn, mn, mx, mn, mn, mx, mx));
    send_request(make_req(mn, mx, mx, mx, mn, mn, mx));
    send_request(make_req(mx, mn, mx, mn, mn, mn, mn));
    send_request(make_req(0, 0, mx, mx, mx, mx, mn));
    send_request(make_req(mn, mn, 1, mx, mx, mx, mx));
    send_request(make_req(0, 0, 3, 1, 1, -1, -1));
    send_request(make_req(-one, one, one, -one, one + 1, -one + 1, one));
  endtask

  task automatic test_random_contacts(int count);
    for (int i = 0; i < count; i++) begin
      quiet = (i >= count / 2 && i < count / 2 + 80);
      send_request(random_contact());
    end
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_cycles = 450;
    for (int i = 0; i < 200; i++) send_request(random_contact());
  endtask

  task automatic test_noise(int count);
    for (int i = 0; i < count; i++)
      send_request(make_req($urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_contacts(250);
    test_backpressure();
    test_noise(80);
    req_valid <= 1'b0;
    while (expected_contacts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("circle_segment_contact_core test passed");
    end else begin
      $display("circle_segment_contact_core test failed");
    end
    $finish;
  end

endmodule

@@ circle_segment_contact_core.f @@
+incdir+rtl
rtl/csc_pkg.sv
rtl/csc_sqrt_pipe.sv
rtl/csc_div_pipe.sv
rtl/circle_segment_contact_core.sv
rtl/csc_checker.sv
verif/tb_circle_segment_contact_core.sv
